// ===== design/sts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the ramped sine tone generator
// register codes, fixed field widths and the quarter-wave table builder
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int PHASE_W   = 32;
	localparam int TOTAL_W   = 24;
	localparam int LEVEL_W   = 15;
	localparam int ROM_W     = 15;
	localparam int SAMPLE_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_PHASE_INC   = 2'd0;
	localparam cfg_idx_t REG_FRAME_TOTAL = 2'd1;
	localparam cfg_idx_t REG_TONE_LEVEL  = 2'd2;

	// odd taylor terms of sin(pi/2 * x) in q30, alternating sign
	localparam logic [63:0] POLY_COEF [6] = '{
		64'd1686629713, 64'd693598668, 64'd85569306,
		64'd5026995, 64'd172272, 64'd3864
	};

	localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

	// one table entry from its q30 position x in [0, 1]
	function automatic logic [ROM_W-1:0] sine_entry(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] pw;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] term;
		logic [63:0] val;
		x2  = (x * x) >> 30;
		pw  = x;
		pos = 64'd0;
		neg = 64'd0;
		for (int t = 0; t < 6; t++) begin
			term = (pw * POLY_COEF[t]) >> 30;
			if (t % 2 == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
			pw = (pw * x2) >> 30;
		end
		val = (pos > neg) ? pos - neg : 64'd0;
		val = (val * 64'd32767 + HALF_Q30) >> 30;
		if (val > 64'd32767) begin
			val = 64'd32767;
		end
		return val[ROM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/sts_sine_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sts_sine_rom: quarter-wave sine table
// QUARTER_LEN+1 magnitudes in q0.15, built at elaboration, registered read
// ----------------------------------------------------------------------------
module sts_sine_rom
	import sts_pkg::*;
#(
	parameter int QUARTER_LEN = 256,
	parameter int IDX_W       = 9
) (
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] idx,
	output logic      [ROM_W-1:0] data
);

	logic [ROM_W-1:0] rom_w [QUARTER_LEN+1];
	logic [ROM_W-1:0] data_q;

	for (genvar k = 0; k <= QUARTER_LEN; k++) begin : g_entry
		localparam logic [63:0] XPOS = (64'(k) << 30) / QUARTER_LEN;
		localparam logic [ROM_W-1:0] ENTRY = sine_entry(XPOS);
		assign rom_w[k] = ENTRY;
	end

	always_ff @(posedge clk) begin
		data_q <= rom_w[idx];
	end

	assign data = data_q;

endmodule
`default_nettype wire

// ===== design/ramped_sine_tone_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ramped_sine_tone_generator: dds sine tone with linear attack and release
// one audio frame per input transaction, scaled by level and envelope
// ----------------------------------------------------------------------------
// a tone frame passes states mul1, mul2, mul3 and fin, a silent frame goes
// straight to fin; fin loads the output register unless a held sample is
// stalled, and no new frame is taken before that; the single shared multiplier
// runs three passes per tone frame (level, envelope, ramp reciprocal)
// reset (arst_n low, asynchronous): registers, phase, frame count cleared,
// tone idle, output empty; no clearing pass, ready right after reset
// ----------------------------------------------------------------------------
module ramped_sine_tone_generator
	import sts_pkg::*;
#(
	parameter int RAMP_FRAMES      = 64,
	parameter int SINE_TABLE_SIZE  = 1024,
	parameter int FRAME_COUNT_BITS = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	// frame request stream
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [7:0]           s_axis_tdata,  // [0] start_req, [7:1] zero
	// sample stream
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [31:0]               m_axis_tdata,  // [31:0] tone_sample
	output logic                      m_axis_tuser,  // [0] active
	output logic                      m_axis_tlast   // final frame of the tone
);

	// table geometry
	localparam int QUARTER_LEN = SINE_TABLE_SIZE / 4;
	localparam int IDX_W       = $clog2(QUARTER_LEN + 1);
	localparam int JW          = 30 + IDX_W;

	// envelope and the reciprocal of the ramp length
	localparam int RAMP_LOG = $clog2(RAMP_FRAMES);
	localparam int EW       = $clog2(RAMP_FRAMES + 1);
	localparam int CW       = (FRAME_COUNT_BITS > EW) ? FRAME_COUNT_BITS : EW;
	localparam int NT       = 15 + RAMP_LOG;          // sample*level*env >> 15
	localparam int RSHIFT   = 15 + 2 * RAMP_LOG;
	localparam int MW       = 16 + RAMP_LOG;          // reciprocal width
	localparam int AW       = 30;                     // multiplier a operand
	localparam int PW       = AW + MW;
	localparam logic [63:0] RECIP =
		((64'd1 << RSHIFT) + 64'(RAMP_FRAMES) - 64'd1) / RAMP_FRAMES;

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_MUL3 = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	typedef logic [FRAME_COUNT_BITS-1:0] frame_t;

	// control state
	logic [2:0]          state_q;
	logic [PHASE_W-1:0]  phase_inc_q;
	logic [TOTAL_W-1:0]  frame_total_q;
	logic [LEVEL_W-1:0]  tone_level_q;
	logic [PHASE_W-1:0]  phase_q;
	frame_t              frame_q;
	logic                running_q;
	logic                out_valid_q;

	// datapath registers
	logic [EW-1:0]       env_q;
	logic                neg_q;
	logic                last_q;
	logic                run_q;
	logic [PW-1:0]       prod_q;
	logic [31:0]         out_data_q;
	logic                out_active_q;
	logic                out_last_q;

	// frame decision, all from the accepted transaction
	logic                accept;
	logic                start_req;
	frame_t              total_w;
	frame_t              frame_eff;
	logic [PHASE_W-1:0]  phase_eff;
	logic                run_pre;
	logic                run_now;
	frame_t              remaining_w;
	frame_t              min_w;
	logic [CW-1:0]       min_ext;
	logic [EW-1:0]       env_w;

	// table addressing
	logic [1:0]          quad_w;
	logic [JW-1:0]       jprod_w;
	logic [IDX_W-1:0]    j_w;
	logic [IDX_W-1:0]    rom_idx;
	logic [ROM_W-1:0]    rom_data;

	// shared multiplier
	logic [AW-1:0]       mul_a;
	logic [MW-1:0]       mul_b;
	logic [PW-1:0]       mul_w;

	// final sample
	logic [ROM_W-1:0]    mag_w;
	logic [SAMPLE_W-1:0] mag16;
	logic [SAMPLE_W-1:0] s16_w;
	logic                out_load;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign start_req     = s_axis_tdata[0];

	// total is masked to the frame counter width
	assign total_w   = FRAME_COUNT_BITS'(frame_total_q);
	assign frame_eff = start_req ? '0 : frame_q;
	assign phase_eff = start_req ? '0 : phase_q;
	assign run_pre   = start_req ? (total_w != '0) : running_q;
	// a total lowered below the running frame stops the tone at once
	assign run_now   = run_pre && (frame_eff < total_w);

	assign remaining_w = total_w - frame_eff - frame_t'(1);
	assign min_w       = (remaining_w < frame_eff) ? remaining_w : frame_eff;
	assign min_ext     = CW'(min_w);
	assign env_w       = (min_ext > CW'(RAMP_FRAMES)) ? EW'(RAMP_FRAMES) : EW'(min_ext);

	// quadrant symmetry: odd quadrants run the table backwards
	assign quad_w  = phase_eff[PHASE_W-1 -: 2];
	assign jprod_w = JW'(phase_eff[29:0]) * JW'(QUARTER_LEN);
	assign j_w     = jprod_w[30 +: IDX_W];
	assign rom_idx = quad_w[0] ? (IDX_W'(QUARTER_LEN) - j_w) : j_w;

	sts_sine_rom #(
		.QUARTER_LEN (QUARTER_LEN),
		.IDX_W       (IDX_W)
	) u_rom (
		.clk  (clk),
		.idx  (rom_idx),
		.data (rom_data)
	);

	// operand select: table*level, then *envelope, then *reciprocal of ramp
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL1: begin
				mul_a = AW'(rom_data);
				mul_b = MW'(tone_level_q);
			end
			ST_MUL2: begin
				mul_a = prod_q[AW-1:0];
				mul_b = MW'(env_q);
			end
			ST_MUL3: begin
				mul_a = AW'(prod_q[15 +: NT]);
				mul_b = RECIP[MW-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_w = PW'(mul_a) * PW'(mul_b);

	// magnitude is floor(table*level*env / (32768*ramp)), always below 2^15
	assign mag_w    = prod_q[RSHIFT +: ROM_W];
	assign mag16    = {1'b0, mag_w};
	assign s16_w    = neg_q ? (SAMPLE_W'(0) - mag16) : mag16;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	// configuration, tone state and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_inc_q   <= '0;
			frame_total_q <= '0;
			tone_level_q  <= '0;
			phase_q       <= '0;
			frame_q       <= '0;
			running_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PHASE_INC:   phase_inc_q   <= cfg_data;
					REG_FRAME_TOTAL: frame_total_q <= cfg_data[TOTAL_W-1:0];
					REG_TONE_LEVEL:  tone_level_q  <= cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (run_now) begin
							phase_q   <= phase_eff + phase_inc_q;
							frame_q   <= frame_eff + frame_t'(1);
							running_q <= (remaining_w != '0);
							state_q   <= ST_MUL1;
						end else begin
							phase_q   <= phase_eff;
							frame_q   <= frame_eff;
							running_q <= 1'b0;
							state_q   <= ST_FIN;
						end
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-frame payload
	always_ff @(posedge clk) begin
		if (accept) begin
			env_q  <= env_w;
			neg_q  <= quad_w[1];
			last_q <= (remaining_w == '0);
			run_q  <= run_now;
		end
		if (state_q == ST_MUL1 || state_q == ST_MUL2 || state_q == ST_MUL3) begin
			prod_q <= mul_w;
		end
		if (out_load) begin
			out_data_q   <= run_q ? {s16_w, 16'h0000} : 32'h0000_0000;
			out_active_q <= run_q;
			out_last_q   <= run_q && last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_active_q;
	assign m_axis_tlast  = out_last_q;

	// an accepted transaction always starts either the multiply passes or the silent path
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_MUL1 || state_q == ST_FIN))
		else $error("sequencer did not leave idle after an input transaction");

	// the final frame is always a tone frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
		else $error("last flagged on a silent frame");

	// silence carries a zero sample
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'h0000_0000))
		else $error("silent frame with non-zero sample");

	// a stalled result is never overwritten by the next frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("pending sample lost or changed");

endmodule
`default_nettype wire

// ===== test/ramped_sine_tone_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_sine_tone_generator_tb: self-checking bench for the sine tone block
// a short directed set (silence after reset, a three-frame tone, restart,
// total lowered under a running tone, widest total), then random tones with
// random settings, sender bursts and receiver stalls; every sample frame is
// checked field by field against a predictor held in the bench
// ----------------------------------------------------------------------------
module ramped_sine_tone_generator_tb;
	import sts_pkg::*;

	localparam int RAMP_LEN      = 64;     // envelope ramp length in frames
	localparam int QUARTER       = 256;    // quarter-wave table length
	localparam int RANDOM_FRAMES = 780;    // frame transactions in the random part
	localparam int SETTLE_CYCLES = 10;     // idle cycles after the drain, letting the pipeline empty
	localparam int DRAIN_GUARD   = 4000;   // cycles allowed for outstanding frames
	localparam int TIMEOUT_NS    = 5_000_000;

	// index past the end of the register map, writes to it are dropped
	localparam cfg_idx_t REG_SPARE = 2'd3;

	// odd taylor terms of sin(pi/2 * x) in q30, alternating sign
	localparam logic [63:0] TAYLOR_Q30 [6] = '{
		64'd1686629713, 64'd693598668, 64'd85569306,
		64'd5026995, 64'd172272, 64'd3864
	};

	typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_mode_t;

	typedef struct {
		logic [31:0] sample;
		logic        active;
		logic        last;
	} frame_t;

	// clock, reset and block inputs, all known from time zero
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	cfg_idx_t    cfg_index     = REG_PHASE_INC;
	logic [31:0] cfg_data      = 32'd0;
	logic        s_axis_tvalid = 1'b0;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        m_axis_tready = 1'b0;

	logic        cfg_ready;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	ramped_sine_tone_generator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [0] start_req, [7:1] zero
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [31:0] tone_sample
		.m_axis_tuser  (m_axis_tuser),   // [0] active
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// predictor: register copies, tone state and the quarter-wave table
	// ------------------------------------------------------------------------
	logic [31:0] step_inc   = 32'd0;
	logic [23:0] tone_total = 24'd0;
	logic [14:0] tone_lvl   = 15'd0;
	logic [31:0] phase_acc  = 32'd0;
	logic [23:0] frame_idx  = 24'd0;
	logic        tone_on    = 1'b0;
	logic [14:0] quarter_wave [0:QUARTER];

	frame_t      pending_frames [$];   // expected frames, oldest first
	int          mismatches  = 0;
	int          items_sent  = 0;
	int          burst_left  = 0;

	// table entry k is the rounded q15 value of the polynomial at k/QUARTER
	initial begin
		logic [63:0] x, x2, pw, plus, minus, term, acc;
		for (int k = 0; k <= QUARTER; k++) begin
			x     = (64'(k) << 30) / QUARTER;
			x2    = (x * x) >> 30;
			pw    = x;
			plus  = 64'd0;
			minus = 64'd0;
			for (int t = 0; t < 6; t++) begin
				term = (pw * TAYLOR_Q30[t]) >> 30;
				if (t % 2 == 1) begin
					minus += term;
				end else begin
					plus += term;
				end
				pw = (pw * x2) >> 30;
			end
			acc = (plus > minus) ? plus - minus : 64'd0;
			acc = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
			if (acc > 64'd32767) begin
				acc = 64'd32767;
			end
			quarter_wave[k] = acc[14:0];
		end
	end

	// works out the frame for one request and advances the tone state
	function automatic frame_t synth_frame(input logic start);
		frame_t      f;
		logic [31:0] remain;
		logic [31:0] env;
		logic [1:0]  quad;
		logic [8:0]  slot;
		logic [63:0] mag;
		f = '{32'd0, 1'b0, 1'b0};
		if (start) begin
			frame_idx = 24'd0;
			phase_acc = 32'd0;
			tone_on   = (tone_total != 24'd0);
		end
		// a total lowered under the running frame stops the tone at once
		if (tone_on && frame_idx >= tone_total) begin
			tone_on = 1'b0;
		end
		if (!tone_on) begin
			return f;
		end
		remain = 32'(tone_total) - 32'(frame_idx) - 32'd1;
		env    = 32'(frame_idx);
		if (remain < env) begin
			env = remain;
		end
		if (env > RAMP_LEN) begin
			env = RAMP_LEN;
		end
		// quadrant from the top two bits, table slot from the next eight
		quad = phase_acc[31:30];
		slot = quad[0] ? 9'(QUARTER) - {1'b0, phase_acc[29:22]} : {1'b0, phase_acc[29:22]};
		mag  = (64'(quarter_wave[slot]) * 64'(tone_lvl) * 64'(env)) / (64'd32768 * RAMP_LEN);
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		f.sample  = {quad[1] ? 16'(16'd0 - mag[15:0]) : mag[15:0], 16'h0000};
		f.active  = 1'b1;
		f.last    = (remain == 32'd0);
		phase_acc = phase_acc + step_inc;
		frame_idx = frame_idx + 24'd1;
		if (remain == 32'd0) begin
			tone_on = 1'b0;
		end
		return f;
	endfunction

	// ------------------------------------------------------------------------
	// sample checker: each accepted frame against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		frame_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected frame sample=%h active=%b last=%b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				mismatches++;
			end else begin
				want = pending_frames.pop_front();
				if (m_axis_tdata !== want.sample) begin
					$display("%0t: sample expected %h actual %h",
						$time, want.sample, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tuser !== want.active) begin
					$display("%0t: active expected %b actual %b",
						$time, want.active, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: last expected %b actual %b",
						$time, want.last, m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver back-pressure: steady, random or sparse ready, mode held for
	// a random stretch of cycles
	// ------------------------------------------------------------------------
	rx_mode_t    rx_mode  = RX_STEADY;
	int          rx_run   = 0;
	logic [1:0]  rx_phase = 2'd0;

	always @(posedge clk) begin
		if (rx_run == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_run  <= $urandom_range(40, 300);
		end else begin
			rx_run <= rx_run - 1;
		end
		case (rx_mode)
			RX_STEADY: begin
				m_axis_tready <= 1'b1;
			end
			RX_RANDOM: begin
				m_axis_tready <= ($urandom_range(0, 2) != 0);
			end
			default: begin
				m_axis_tready <= (rx_phase == 2'd0);
			end
		endcase
		rx_phase <= rx_phase + 2'd1;
	end

	// ------------------------------------------------------------------------
	// shared tasks
	// ------------------------------------------------------------------------

	// one frame request; the sender runs in bursts with random gaps between
	task automatic send_frame(input logic start);
		int gap;
		if (burst_left == 0) begin
			// about one burst in five is long and has no gap in front
			if ($urandom_range(0, 4) == 0) begin
				gap        = 0;
				burst_left = $urandom_range(30, 80);
			end else begin
				gap        = $urandom_range(0, 10);
				burst_left = $urandom_range(1, 24);
			end
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, start};
		do @(posedge clk); while (!s_axis_tready);
		pending_frames.push_back(synth_frame(start));
		items_sent++;
		burst_left--;
	endtask

	// one register write transaction, valid dropped for a cycle after it
	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PHASE_INC: begin
				step_inc = data;
			end
			REG_FRAME_TOTAL: begin
				tone_total = data[23:0];
			end
			REG_TONE_LEVEL: begin
				tone_lvl = data[14:0];
			end
			default: begin
				// outside the register map, dropped
			end
		endcase
		@(posedge clk);
	endtask

	// stop sending and wait until every expected frame is out, then let the
	// pipeline empty
	task automatic settle();
		int guard;
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		guard      = 0;
		while (pending_frames.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		if (pending_frames.size() != 0) begin
			$display("%0t: %0d frames still expected, none arriving",
				$time, pending_frames.size());
			mismatches++;
			pending_frames.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------------

	// registers clear after reset: a start with zero total stays silent
	task automatic test_idle_after_reset();
		send_frame(1'b0);
		send_frame(1'b1);
		settle();
	endtask

	// three-frame tone at full level, then silence after the last frame;
	// a write past the register map must not disturb anything
	task automatic test_short_tone();
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		write_reg(REG_PHASE_INC, 32'h4000_0000);
		write_reg(REG_FRAME_TOTAL, 32'd3);
		write_reg(REG_TONE_LEVEL, 32'hFFFF_FFFF);
		send_frame(1'b1);
		send_frame(1'b0);
		send_frame(1'b0);
		send_frame(1'b0);
		settle();
	endtask

	// a start in the middle of a tone goes back to frame zero, phase zero
	task automatic test_restart_while_running();
		write_reg(REG_PHASE_INC, 32'h3FFF_FFFF);
		write_reg(REG_FRAME_TOTAL, 32'd5);
		send_frame(1'b1);
		send_frame(1'b0);
		send_frame(1'b0);
		send_frame(1'b1);
		send_frame(1'b0);
		send_frame(1'b0);
		settle();
	endtask

	// tone running, total cut below the current frame: silence at once
	task automatic test_total_lowered();
		write_reg(REG_PHASE_INC, 32'hC000_0001);
		write_reg(REG_FRAME_TOTAL, 32'hAB00_00C8);
		send_frame(1'b1);
		send_frame(1'b0);
		send_frame(1'b0);
		send_frame(1'b0);
		send_frame(1'b0);
		settle();
		write_reg(REG_FRAME_TOTAL, 32'd3);
		send_frame(1'b0);
		send_frame(1'b0);
		settle();
	endtask

	// widest total, largest step, smallest non-zero level
	task automatic test_wide_total();
		write_reg(REG_FRAME_TOTAL, 32'hFFFF_FFFF);
		write_reg(REG_PHASE_INC, 32'hFFFF_FFFF);
		write_reg(REG_TONE_LEVEL, 32'h0000_8001);
		send_frame(1'b1);
		send_frame(1'b0);
		send_frame(1'b0);
		settle();
	endtask

	// ------------------------------------------------------------------------
	// random tones: mostly whole tones with random settings, some continuing
	// the previous tone under new settings, some with noisy start requests
	// ------------------------------------------------------------------------
	task automatic test_random_tones();
		int          goal;
		int          frames;
		int          pause_at;
		logic        carry_on;
		logic        noisy;
		logic [31:0] inc_val;
		logic [31:0] total_val;
		logic [31:0] lvl_val;
		logic        start;
		goal = items_sent + RANDOM_FRAMES;
		while (items_sent < goal) begin
			settle();
			case ($urandom_range(0, 5))
				0: inc_val = 32'd0;
				1: inc_val = 32'hFFFF_FFFF;
				2: inc_val = 32'h0100_0000 * $urandom_range(1, 255);
				default: inc_val = $urandom;
			endcase
			// half the tones are short; some long enough to reach the full
			// envelope; a few empty or huge ones
			case ($urandom_range(0, 9))
				0: total_val = $urandom_range(0, 2);
				1: total_val = $urandom;
				2, 3, 4: total_val = $urandom_range(130, 200);
				default: total_val = $urandom_range(1, 40);
			endcase
			if (total_val[23:0] > 24'd200 || $urandom_range(0, 1) == 0) begin
				total_val[31:24] = $urandom_range(0, 255);
			end
			case ($urandom_range(0, 5))
				0: lvl_val = 32'h7FFF;
				1: lvl_val = 32'd0;
				default: lvl_val = $urandom_range(0, 32767);
			endcase
			lvl_val[31:15] = $urandom;
			// registers in a random order, now and then one left as it was
			for (int r = 0; r < 3; r++) begin
				case (($urandom_range(0, 2) + r) % 3)
					0: begin
						if ($urandom_range(0, 5) != 0) write_reg(REG_PHASE_INC, inc_val);
					end
					1: begin
						if ($urandom_range(0, 5) != 0) write_reg(REG_FRAME_TOTAL, total_val);
					end
					default: begin
						if ($urandom_range(0, 5) != 0) write_reg(REG_TONE_LEVEL, lvl_val);
					end
				endcase
			end
			if ($urandom_range(0, 7) == 0) begin
				write_reg(REG_SPARE, $urandom);
			end
			carry_on = ($urandom_range(0, 3) == 0);
			noisy    = ($urandom_range(0, 7) == 0);
			frames   = (tone_total > 24'd200 ? 120 : int'(tone_total)) + $urandom_range(1, 5);
			// now and then the sender holds off mid-tone until all is out
			pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, frames) : -1;
			for (int i = 0; i < frames; i++) begin
				if (noisy) begin
					start = ($urandom_range(0, 3) == 0);
				end else if (i == 0 && !carry_on) begin
					start = 1'b1;
				end else begin
					start = ($urandom_range(0, 59) == 0);
				end
				send_frame(start);
				if (i == pause_at) begin
					settle();
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_after_reset();
		test_short_tone();
		test_restart_while_running();
		test_total_lowered();
		test_wide_total();
		test_random_tones();
		settle();
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// overall time limit, far beyond the slowest correct run
	initial begin
		#(TIMEOUT_NS);
		$display("%0t: run timed out", $time);
		$display("status: fail");
		$finish;
	end

endmodule
